>>> sv/wcs_pkg.sv
// Shared types and constants for the weighted cosine similarity block.
// Used by every module of the block; depends on nothing.
package wcs_pkg;

   localparam int ELEM_BITS   = 12;
   localparam int WEIGHT_BITS = 8;
   localparam int WELEM_BITS  = ELEM_BITS + WEIGHT_BITS + 1;
   localparam int PROD_BITS   = 2 * WELEM_BITS;
   localparam int DOT_BITS    = 51;
   localparam int EN_BITS     = 50;
   localparam int QUEUE_DEPTH = 4;
   localparam int SIM_BITS    = 16;

   // Shared multiplier: 4 x 2 chunks of CHUNK bits.
   localparam int CHUNK      = 26;
   localparam int MUL_A_BITS = 4 * CHUNK;
   localparam int MUL_B_BITS = 2 * CHUNK;
   localparam int MUL_P_BITS = 6 * CHUNK;

   typedef struct packed {
      logic signed [ELEM_BITS-1:0] ref_elem;
      logic signed [ELEM_BITS-1:0] est_elem;
      logic [WEIGHT_BITS-1:0]      elem_weight;
      logic                        last_elem;
   } req_type;

   typedef struct packed {
      logic signed [SIM_BITS-1:0] similarity;
      logic                       zero_norm;
   } rsp_type;

   typedef struct packed {
      logic signed [DOT_BITS-1:0] dot;
      logic [EN_BITS-1:0]         ref_en;
      logic [EN_BITS-1:0]         est_en;
   } acc_type;

   typedef struct packed {
      logic                  start;
      logic [MUL_A_BITS-1:0] a;
      logic [MUL_B_BITS-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                  done;
      logic [MUL_P_BITS-1:0] prod;
   } mul_rsp_type;

endpackage

>>> sv/wcs_front.sv
// Front end: weights each element pair and accumulates dot product and energies.
// Pushes finished sums into the queue on the last element. Uses wcs_pkg.
module wcs_front #(
   parameter int QUEUE_DEPTH = wcs_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  wcs_pkg::req_type                 req_data,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
   output logic                             push,
   output wcs_pkg::acc_type                 push_data
);
   localparam int WB = wcs_pkg::WELEM_BITS;
   localparam int PB = wcs_pkg::PROD_BITS;
   localparam int DB = wcs_pkg::DOT_BITS;
   localparam int EB = wcs_pkg::EN_BITS;
   localparam int CB = $clog2(QUEUE_DEPTH+1);

   logic s1_vld_ff, s1_last_ff, s2_vld_ff, s2_last_ff;
   logic signed [WB-1:0] wr_ff, we_ff, wr_in, we_in;
   logic signed [PB-1:0] dp_ff, dp_in;
   logic [PB-1:0] rp_ff, ep_ff, rp_in, ep_in;
   logic signed [DB-1:0] dot_ff, dot_in;
   logic [EB-1:0] ren_ff, een_ff, ren_in, een_in;
   logic [DB:0] dot_sum;
   logic [EB:0] ren_sum, een_sum;
   logic [CB+1:0] reserved;
   logic accept;

   // Every last element in flight holds a queue slot, so a push never finds it full.
   assign reserved = (CB+2)'(queue_count) + (CB+2)'(s1_vld_ff & s1_last_ff)
                     + (CB+2)'(s2_vld_ff & s2_last_ff);
   assign req_ready = reserved < (CB+2)'(QUEUE_DEPTH);
   assign accept = req_valid && req_ready;

   always_comb begin
      wr_in = req_data.ref_elem * $signed({1'b0, req_data.elem_weight});
      we_in = req_data.est_elem * $signed({1'b0, req_data.elem_weight});
      dp_in = wr_ff * we_ff;
      rp_in = wr_ff * wr_ff;
      ep_in = we_ff * we_ff;
      dot_sum = {dot_ff[DB-1], dot_ff} + {{(DB+1-PB){dp_ff[PB-1]}}, dp_ff};
      ren_sum = {1'b0, ren_ff} + (EB+1)'(rp_ff);
      een_sum = {1'b0, een_ff} + (EB+1)'(ep_ff);
      if (dot_sum[DB] != dot_sum[DB-1]) begin
         dot_in = {dot_sum[DB], {(DB-1){~dot_sum[DB]}}};
      end else begin
         dot_in = dot_sum[DB-1:0];
      end
      ren_in = ren_sum[EB] ? {EB{1'b1}} : ren_sum[EB-1:0];
      een_in = een_sum[EB] ? {EB{1'b1}} : een_sum[EB-1:0];
   end

   assign push = s2_vld_ff && s2_last_ff;
   assign push_data = '{dot: dot_in, ref_en: ren_in, est_en: een_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         dot_ff <= '0;
         ren_ff <= '0;
         een_ff <= '0;
      end else begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         if (s2_vld_ff) begin
            dot_ff <= s2_last_ff ? '0 : dot_in;
            ren_ff <= s2_last_ff ? '0 : ren_in;
            een_ff <= s2_last_ff ? '0 : een_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      wr_ff <= wr_in;
      we_ff <= we_in;
      s1_last_ff <= req_data.last_elem;
      dp_ff <= dp_in;
      rp_ff <= rp_in;
      ep_ff <= ep_in;
      s2_last_ff <= s1_last_ff;
   end
endmodule

>>> sv/wcs_fifo.sv
// Short queue of finished accumulator sets between front and back end.
// Uses wcs_pkg for the entry type.
module wcs_fifo #(
   parameter int QUEUE_DEPTH = wcs_pkg::QUEUE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  wcs_pkg::acc_type                 push_data,
   input  logic                             pop,
   output wcs_pkg::acc_type                 head,
   output logic                             empty,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CB = $clog2(QUEUE_DEPTH+1);

   wcs_pkg::acc_type mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CB-1:0] count_ff;

   assign head = mem_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CB'(push) - CB'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < CB'(QUEUE_DEPTH)) || pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue read while empty");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on write");
endmodule

>>> sv/wcs_mul.sv
// Shared sequential multiplier: 104 x 52 bits as eight 26 x 26 partial products.
// Uses wcs_pkg for widths and the request and response structs.
module wcs_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  wcs_pkg::mul_req_type mul_req,
   output wcs_pkg::mul_rsp_type mul_rsp
);
   localparam int CH = wcs_pkg::CHUNK;
   localparam int PB = wcs_pkg::MUL_P_BITS;

   logic busy_ff, pp_vld_ff, pp_last_ff, done_ff;
   logic [3:0] cnt_ff;
   logic [2:0] sh_ff;
   logic [wcs_pkg::MUL_A_BITS-1:0] a_ff;
   logic [wcs_pkg::MUL_B_BITS-1:0] b_ff;
   logic [2*CH-1:0] pp_ff;
   logic [PB-1:0] acc_ff;
   logic issue;

   assign issue = busy_ff && !mul_req.start && (cnt_ff != 4'd8);
   assign mul_rsp = '{done: done_ff, prod: acc_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pp_vld_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= !mul_req.start && pp_vld_ff && pp_last_ff;
         if (mul_req.start) begin
            busy_ff <= 1'b1;
            pp_vld_ff <= 1'b0;
            cnt_ff <= '0;
         end else begin
            pp_vld_ff <= issue;
            if (issue) begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            if (pp_vld_ff && pp_last_ff) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Partial product i*j lands at a weight of 2^(CHUNK*(i+j)).
   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         a_ff <= mul_req.a;
         b_ff <= mul_req.b;
         acc_ff <= '0;
      end else begin
         if (issue) begin
            pp_ff <= a_ff[cnt_ff[2:1]*CH +: CH] * b_ff[cnt_ff[0]*CH +: CH];
            sh_ff <= 3'(cnt_ff[2:1]) + 3'(cnt_ff[0]);
            pp_last_ff <= cnt_ff == 4'd7;
         end
         if (pp_vld_ff) begin
            acc_ff <= acc_ff + (PB'(pp_ff) << (sh_ff * CH));
         end
      end
   end
endmodule

>>> sv/wcs_back.sv
// Back end: turns one accumulator set into a Q1.15 similarity by a bitwise
// search on the root ratio, using wcs_mul. Holds the result register. Uses wcs_pkg.
module wcs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 queue_empty,
   input  wcs_pkg::acc_type     head,
   output logic                 pop,
   output wcs_pkg::mul_req_type mul_req,
   input  wcs_pkg::mul_rsp_type mul_rsp,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wcs_pkg::rsp_type     rsp_data
);
   localparam int SB = wcs_pkg::SIM_BITS;
   localparam int DB = wcs_pkg::DOT_BITS;
   localparam int EB = wcs_pkg::EN_BITS;
   localparam int PB = wcs_pkg::MUL_P_BITS;
   localparam int AB = wcs_pkg::MUL_A_BITS;
   localparam int BB = wcs_pkg::MUL_B_BITS;
   localparam int TB = $clog2(SB);
   localparam logic [SB-1:0] Q_LIMIT = SB'(1) << (SB-1);

   typedef enum logic [2:0] {S_IDLE, S_P, S_M, S_TRY, S_O, S_L, S_FIN} state_type;

   state_type state_ff;
   logic start_ff, neg_ff, zero_ff, rsp_valid_ff;
   logic [AB-1:0] a_ff;
   logic [BB-1:0] b_ff;
   logic [DB-1:0] mag_ff;
   logic [2*EB-1:0] p_ff;
   logic [2*DB-1:0] m2_ff;
   logic [SB-1:0] q_ff, c_ff, cand, odd;
   logic [TB-1:0] bit_ff;
   logic [SB-1:0] sim_in;
   logic [PB-1:0] rhs;
   logic fin_fire;
   wcs_pkg::rsp_type rsp_ff;

   assign pop = (state_ff == S_IDLE) && !queue_empty;
   assign mul_req = '{start: start_ff, a: a_ff, b: b_ff};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      cand = q_ff | (SB'(1) << bit_ff);
      // 2c-1 of the largest candidate is 65535, which still fits the field.
      odd = {cand[SB-2:0], 1'b0} - 1'b1;
      // The candidate passes when (2c-1)^2 * Er * Ee <= 2^32 * dot^2.
      rhs = PB'({m2_ff, 32'b0});
      fin_fire = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
      if (zero_ff) begin
         sim_in = '0;
      end else if (neg_ff) begin
         sim_in = '0 - q_ff;
      end else begin
         sim_in = (q_ff == Q_LIMIT) ? Q_LIMIT - 1'b1 : q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin_fire || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            S_IDLE: begin
               start_ff <= !queue_empty && head.ref_en != '0 && head.est_en != '0;
               if (!queue_empty) begin
                  neg_ff <= head.dot[DB-1];
                  mag_ff <= head.dot[DB-1] ? DB'(0) - DB'(head.dot) : DB'(head.dot);
                  q_ff <= '0;
                  if (head.ref_en == '0 || head.est_en == '0) begin
                     zero_ff <= 1'b1;
                     state_ff <= S_FIN;
                  end else begin
                     zero_ff <= 1'b0;
                     a_ff <= AB'(head.ref_en);
                     b_ff <= BB'(head.est_en);
                     state_ff <= S_P;
                  end
               end
            end
            S_P: begin
               start_ff <= mul_rsp.done;
               if (mul_rsp.done) begin
                  p_ff <= mul_rsp.prod[2*EB-1:0];
                  a_ff <= AB'(mag_ff);
                  b_ff <= BB'(mag_ff);
                  state_ff <= S_M;
               end
            end
            S_M: begin
               start_ff <= 1'b0;
               if (mul_rsp.done) begin
                  m2_ff <= mul_rsp.prod[2*DB-1:0];
                  bit_ff <= TB'(SB-1);
                  state_ff <= S_TRY;
               end
            end
            S_TRY: begin
               start_ff <= (cand <= Q_LIMIT);
               if (cand > Q_LIMIT) begin
                  if (bit_ff == '0) begin
                     state_ff <= S_FIN;
                  end else begin
                     bit_ff <= bit_ff - 1'b1;
                  end
               end else begin
                  // The square of 2c-1 starts here while the candidate is kept.
                  c_ff <= cand;
                  a_ff <= AB'(odd);
                  b_ff <= BB'(odd);
                  state_ff <= S_O;
               end
            end
            S_O: begin
               start_ff <= mul_rsp.done;
               if (mul_rsp.done) begin
                  a_ff <= AB'(p_ff);
                  b_ff <= BB'(mul_rsp.prod[2*SB-1:0]);
                  state_ff <= S_L;
               end
            end
            S_L: begin
               start_ff <= 1'b0;
               if (mul_rsp.done) begin
                  if (mul_rsp.prod <= rhs) begin
                     q_ff <= c_ff;
                  end
                  if (bit_ff == '0) begin
                     state_ff <= S_FIN;
                  end else begin
                     bit_ff <= bit_ff - 1'b1;
                     state_ff <= S_TRY;
                  end
               end
            end
            S_FIN: begin
               start_ff <= 1'b0;
               if (fin_fire) begin
                  rsp_ff <= '{similarity: sim_in, zero_norm: zero_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               start_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_zero_sim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.zero_norm |-> rsp_ff.similarity == '0)
      else $error("zero norm result with nonzero similarity");
   a_done_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> state_ff == S_P || state_ff == S_M || state_ff == S_O
                       || state_ff == S_L)
      else $error("multiplier finished while no one waits");
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_FIN)
      else $error("result raised outside the final state");
endmodule

>>> sv/weighted_cosine_similarity_top.sv
// Weighted cosine similarity: one element triple per cycle is accepted while the
// queue has room; each vector's result follows up to 2 + 16 x 2 shared-multiplier
// operations after its last element, set by the bitwise root search over the
// eight-pass 26 x 26 multiplier. Up to four finished vectors wait in the queue,
// so short vectors are limited by that search.
module weighted_cosine_similarity_top #(
   parameter int QUEUE_DEPTH = wcs_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wcs_pkg::rsp_type rsp_data
);
   logic push, pop, empty;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
   wcs_pkg::acc_type push_data, head;
   wcs_pkg::mul_req_type mul_req;
   wcs_pkg::mul_rsp_type mul_rsp;

   wcs_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .queue_count(count), .push(push), .push_data(push_data)
   );

   wcs_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .pop(pop),
      .head(head), .empty(empty), .count(count)
   );

   wcs_mul u_mul (
      .clock(clock), .reset(reset), .mul_req(mul_req), .mul_rsp(mul_rsp)
   );

   wcs_back u_back (
      .clock(clock), .reset(reset), .queue_empty(empty), .head(head), .pop(pop),
      .mul_req(mul_req), .mul_rsp(mul_rsp), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule

>>> dv/tb.sv
// Self-checking testbench for weighted_cosine_similarity_top: streams element
// triples under several idle and stall mixes and checks every result.
// Depends on wcs_pkg and the weighted_cosine_similarity_top RTL.
module tb;

   localparam longint DOT_HI = (64'sd1 <<< 50) - 1;
   localparam longint DOT_LO = -(64'sd1 <<< 50);
   localparam longint EN_HI  = (64'sd1 <<< 50) - 1;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   wcs_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   wcs_pkg::rsp_type rsp_data;

   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      errors = 0;
   wcs_pkg::rsp_type sim_expected[$];

   // Running weighted sums, mirrored from the accepted transactions.
   longint  dot_sum = 0;
   longint  ref_sum = 0;
   longint  est_sum = 0;

   weighted_cosine_similarity_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #4 clock = ~clock;

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // round(32768 * |dot| / sqrt(ref * est)) by searching the largest q with
   // (2q-1)^2 * ref * est <= 4 * 2^30 * dot^2.
   function automatic wcs_pkg::rsp_type cosine_of(longint dot, longint ren, longint een);
      wcs_pkg::rsp_type r;
      logic [139:0]     prod_en;
      logic [139:0]     rhs;
      logic [139:0]     lhs;
      logic [139:0]     mag;
      logic [139:0]     odd;
      int unsigned      lo;
      int unsigned      hi;
      int unsigned      mid;
      r = '0;
      if (ren == 0 || een == 0) begin
         r.zero_norm = 1'b1;
         return r;
      end
      prod_en = 140'(ren) * 140'(een);
      mag = (dot < 0) ? 140'(-dot) : 140'(dot);
      rhs = (mag << 16) * (mag << 16);
      lo = 0;
      hi = 32768;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         odd = 140'(2 * mid - 1);
         lhs = odd * odd * prod_en;
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      if (dot < 0) r.similarity = 16'(-int'(lo));
      else r.similarity = 16'((lo > 32767) ? 32767 : lo);
      return r;
   endfunction

   task automatic accumulate(wcs_pkg::req_type x);
      longint w;
      longint wr;
      longint we;
      w  = longint'(x.elem_weight);
      wr = longint'(x.ref_elem) * w;
      we = longint'(x.est_elem) * w;
      dot_sum = clamp(dot_sum + wr * we, DOT_LO, DOT_HI);
      ref_sum = clamp(ref_sum + wr * wr, 0, EN_HI);
      est_sum = clamp(est_sum + we * we, 0, EN_HI);
      if (x.last_elem) begin
         sim_expected.insert(sim_expected.size(), cosine_of(dot_sum, ref_sum, est_sum));
         dot_sum = 0;
         ref_sum = 0;
         est_sum = 0;
      end
   endtask

   // Called at a rising edge; returns at the edge where the transaction is taken, or after the idle time it inserts.
   task automatic send_elem(logic signed [11:0] r, logic signed [11:0] e,
                            logic [7:0] w, logic last);
      wcs_pkg::req_type x;
      x.ref_elem = r;
      x.est_elem = e;
      x.elem_weight = w;
      x.last_elem = last;
      req_valid <= 1'b1;
      req_data <= x;
      do @(posedge clock); while (!req_ready);
      accumulate(x);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sim_expected.size() == 0) begin
            $display("%0t: unexpected result sim=%0d zero=%0b", $time,
                     rsp_data.similarity, rsp_data.zero_norm);
            errors++;
         end else begin
            if (rsp_data.similarity !== sim_expected[0].similarity) begin
               $display("%0t: similarity expected %0d actual %0d", $time,
                        sim_expected[0].similarity, rsp_data.similarity);
               errors++;
            end
            if (rsp_data.zero_norm !== sim_expected[0].zero_norm) begin
               $display("%0t: zero_norm expected %0b actual %0b", $time,
                        sim_expected[0].zero_norm, rsp_data.zero_norm);
               errors++;
            end
            void'(sim_expected.pop_front());
         end
      end
   end

   task automatic test_extremes();
      send_elem(12'sd2047, 12'sd2047, 8'd255, 1'b1);     // identical: +1 saturates
      send_elem(-12'sd2048, 12'sd2047, 8'd255, 1'b1);    // opposite sign
      send_elem(-12'sd2048, -12'sd2048, 8'd255, 1'b1);
      send_elem(12'sd1000, 12'sd1000, 8'd0, 1'b1);       // zero weight: both energies zero
      send_elem(12'sd0, 12'sd500, 8'd128, 1'b1);         // reference energy zero only
      send_elem(12'sd700, 12'sd0, 8'd1, 1'b1);           // estimated energy zero only
      send_elem(12'sd1024, 12'sd0, 8'd255, 1'b0);        // orthogonal pair
      send_elem(12'sd0, -12'sd1024, 8'd255, 1'b1);
      send_elem(12'sd1, 12'sd1, 8'd1, 1'b0);             // tiny values
      send_elem(-12'sd1, 12'sd1, 8'd1, 1'b0);
      send_elem(12'sd1, 12'sd2, 8'd1, 1'b1);
      send_elem(12'sd300, -12'sd300, 8'd77, 1'b0);       // exactly opposite
      send_elem(-12'sd5, 12'sd5, 8'd200, 1'b1);
      send_elem(12'sd2047, 12'sd3, 8'd255, 1'b0);
      send_elem(12'sd3, 12'sd2047, 8'd128, 1'b0);
      send_elem(-12'sd2048, -12'sd1, 8'd64, 1'b1);
   endtask

   // Long vectors of extreme values build very large accumulator sums.
   task automatic test_long_vectors();
      for (int i = 0; i < 100; i++) send_elem(12'sd2047, 12'sd2047, 8'd255, i == 99);
      for (int i = 0; i < 100; i++) send_elem(-12'sd2048, 12'sd2047, 8'd255, i == 99);
   endtask

   task automatic random_vectors(int n_items);
      int left;
      int len;
      int kind;
      logic signed [11:0] r;
      logic signed [11:0] e;
      left = n_items;
      while (left > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
         kind = $urandom_range(9);
         for (int i = 0; i < len; i++) begin
            r = 12'($urandom);
            case (kind)
               0: e = r;                  // parallel vectors
               1: e = -r;                 // antiparallel vectors
               2: e = 12'($urandom_range(3)) - 12'sd1;
               default: e = 12'($urandom);
            endcase
            send_elem(r, e, (kind == 3) ? 8'($urandom_range(1)) : 8'($urandom),
                      i == len - 1);
         end
         left -= len;
      end
   endtask

   task automatic test_no_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_vectors(200);
   endtask

   task automatic test_sender_idle();
      send_idle_pct = 77;
      recv_stall_pct = 0;
      random_vectors(150);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct = 0;
      recv_stall_pct = 77;
      random_vectors(150);
   endtask

   task automatic test_both_idle();
      send_idle_pct = 22;
      recv_stall_pct = 22;
      random_vectors(150);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_long_vectors();
      test_no_idle();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      req_valid <= 1'b0;
      while (sim_expected.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #40000000;
      $display("Verification failed");
      $finish;
   end

endmodule

>>> files.f
sv/wcs_pkg.sv
sv/wcs_front.sv
sv/wcs_fifo.sv
sv/wcs_mul.sv
sv/wcs_back.sv
sv/weighted_cosine_similarity_top.sv
dv/tb.sv
